### design/kphd_pkg.sv
package kphd_pkg;

    localparam int ROW_COUNT_DEFAULT    = 4;
    localparam int COLUMN_COUNT_DEFAULT = 4;

    localparam int KEY_BITS      = 16;
    localparam int KEY_INDEX_W   = 4;
    localparam int TIME_W        = 32;
    localparam int THRESHOLD_W   = 16;

    localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = 16'd1000;

    // Number of scanned keys, capped at the width of the key field.
    function automatic int key_total(input int rows, input int cols);
        int n;
        n = rows * cols;
        if (n > KEY_BITS)
        begin
            n = KEY_BITS;
        end
        return n;
    endfunction

endpackage

### design/kphd_if.sv
interface kphd_frame_if;
    logic                              valid;
    logic                              ready;
    logic [kphd_pkg::KEY_BITS-1:0]     key_down_bits;
    logic [kphd_pkg::TIME_W-1:0]       now_ms;

    modport source (output valid, output key_down_bits, output now_ms, input ready);
    modport sink   (input valid, input key_down_bits, input now_ms, output ready);
endinterface

interface kphd_result_if;
    logic                              valid;
    logic                              ready;
    logic                              pressed;
    logic                              held;
    logic [kphd_pkg::KEY_INDEX_W-1:0]  last_key;

    modport source (output valid, output pressed, output held, output last_key, input ready);
    modport sink   (input valid, input pressed, input held, input last_key, output ready);
endinterface

interface kphd_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [kphd_pkg::THRESHOLD_W-1:0]  hold_threshold_ms;

    modport source (output valid, output hold_threshold_ms, input ready);
    modport sink   (input valid, input hold_threshold_ms, output ready);
endinterface

### design/keypad_press_hold_detector.sv
// Keypad press/hold detector. Each frame beat carries the down state of every
// key (bit column*ROW_COUNT+row) and a millisecond timestamp; each frame gives
// exactly one result beat, in order. A result flags the first released key in
// scan order as held when now_ms minus the shared press time (32-bit, wrapping)
// reaches hold_threshold_ms, else as pressed; a key going down earlier in scan
// order than that release restarts the press time first. last_key is the
// highest-numbered down key, kept from earlier frames when none is down. Bits
// at or above min(ROW_COUNT*COLUMN_COUNT, 16) are ignored. The block takes one
// frame per cycle while the result channel is ready; a frame passes an input
// register and then a result register, and the only limit is the result
// channel's ready. The threshold register resets to 1000 ms; the user must
// write it only with the block idle, which the block itself does not enforce;
// its port is always ready.
module keypad_press_hold_detector #(
    parameter int ROW_COUNT    = kphd_pkg::ROW_COUNT_DEFAULT,
    parameter int COLUMN_COUNT = kphd_pkg::COLUMN_COUNT_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    kphd_frame_if.sink           frame,
    kphd_result_if.source        result,
    kphd_cfg_if.sink             cfg
);

    localparam int KEY_TOTAL = kphd_pkg::key_total(ROW_COUNT, COLUMN_COUNT);
    localparam logic [kphd_pkg::KEY_BITS-1:0] KEY_MASK =
        kphd_pkg::KEY_BITS'((33'd1 << KEY_TOTAL) - 33'd1);

    // Threshold register.
    logic [kphd_pkg::THRESHOLD_W-1:0] threshold_reg;

    // Input stage.
    logic                              s1_valid_reg;
    logic [kphd_pkg::KEY_BITS-1:0]     s1_keys_reg;
    logic [kphd_pkg::TIME_W-1:0]       s1_now_reg;

    // Scan state; last_key_reg doubles as the result's last_key field.
    logic [kphd_pkg::KEY_BITS-1:0]     prev_keys_reg;
    logic [kphd_pkg::TIME_W-1:0]       press_time_reg;
    logic [kphd_pkg::KEY_INDEX_W-1:0]  last_key_reg;

    // Result register.
    logic                              out_valid_reg;
    logic                              pressed_reg;
    logic                              held_reg;

    logic                              frame_take;
    logic                              s2_load;

    logic [kphd_pkg::KEY_BITS-1:0]     rise_keys;
    logic [kphd_pkg::KEY_BITS-1:0]     fall_keys;
    logic [kphd_pkg::KEY_BITS-1:0]     first_fall;
    logic [kphd_pkg::KEY_BITS-1:0]     before_fall;
    logic                              early_rise;
    logic                              any_fall;
    logic [kphd_pkg::TIME_W-1:0]       elapsed;
    logic                              is_held;
    logic                              any_down;
    logic [kphd_pkg::KEY_INDEX_W-1:0]  top_key;

    logic [kphd_pkg::TIME_W-1:0]       press_time_next;
    logic [kphd_pkg::KEY_INDEX_W-1:0]  last_key_next;

    // Result stage advances whenever the result register is empty or draining;
    // the input stage refills as the result stage takes its frame.
    assign s2_load    = s1_valid_reg && (!out_valid_reg || result.ready);
    assign frame.ready = !s1_valid_reg || s2_load;
    assign frame_take = frame.valid && frame.ready;
    assign cfg.ready  = 1'b1;

    always_comb
    begin
        // Rises and falls against the previous frame.
        rise_keys   = ~prev_keys_reg & s1_keys_reg;
        fall_keys   = prev_keys_reg & ~s1_keys_reg;
        // Isolate the first release in scan order; keys below it form the
        // mask of rises that still restart the press time. With no release
        // the mask covers every key.
        first_fall  = fall_keys & (~fall_keys + kphd_pkg::KEY_BITS'(1));
        before_fall = first_fall - kphd_pkg::KEY_BITS'(1);
        early_rise  = |(rise_keys & before_fall);
        any_fall    = |fall_keys;

        // An early rise sets the press time to now, so nothing has elapsed.
        elapsed     = early_rise ? '0 : (s1_now_reg - press_time_reg);
        is_held     = any_fall &&
                      (elapsed >= {{(kphd_pkg::TIME_W - kphd_pkg::THRESHOLD_W){1'b0}},
                                   threshold_reg});

        press_time_next = early_rise ? s1_now_reg : press_time_reg;
    end

    // Highest-numbered down key.
    always_comb
    begin
        any_down = 1'b0;
        top_key  = '0;
        for (int i = 0; i < KEY_TOTAL; i++)
        begin
            if (s1_keys_reg[i])
            begin
                any_down = 1'b1;
                top_key  = kphd_pkg::KEY_INDEX_W'(i);
            end
        end
        last_key_next = any_down ? top_key : last_key_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg  <= kphd_pkg::THRESHOLD_RESET;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            prev_keys_reg  <= '0;
            press_time_reg <= '0;
            last_key_reg   <= '0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                threshold_reg <= cfg.hold_threshold_ms;
            end

            if (frame.ready)
            begin
                s1_valid_reg <= frame.valid;
            end

            if (s2_load)
            begin
                out_valid_reg  <= 1'b1;
                prev_keys_reg  <= s1_keys_reg;
                press_time_reg <= press_time_next;
                last_key_reg   <= last_key_next;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge clk)
    begin
        if (frame_take)
        begin
            s1_keys_reg <= frame.key_down_bits & KEY_MASK;
            s1_now_reg  <= frame.now_ms;
        end
        if (s2_load)
        begin
            pressed_reg <= any_fall && !is_held;
            held_reg    <= is_held;
        end
    end

    assign result.valid    = out_valid_reg;
    assign result.pressed  = pressed_reg;
    assign result.held     = held_reg;
    assign result.last_key = last_key_reg;

endmodule

### design/kphd_checker.sv
module kphd_checker #(
    parameter int ROW_COUNT    = kphd_pkg::ROW_COUNT_DEFAULT,
    parameter int COLUMN_COUNT = kphd_pkg::COLUMN_COUNT_DEFAULT
) (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              frame_ready,
    input logic                              cfg_valid,
    input logic                              cfg_ready,
    input logic                              result_valid,
    input logic                              result_ready,
    input logic                              result_pressed,
    input logic                              result_held,
    input logic [kphd_pkg::KEY_INDEX_W-1:0]  result_last_key
);

    localparam int KEY_TOTAL = kphd_pkg::key_total(ROW_COUNT, COLUMN_COUNT);

    // A release is either a press or a hold, never both.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(result_pressed && result_held))
        else $error("pressed and held both set");

    // An empty result register never blocks a frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> frame_ready)
        else $error("frame stalled with result register empty");

    // Reported key stays inside the scanned matrix.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ({1'b0, result_last_key} < (kphd_pkg::KEY_INDEX_W + 1)'(KEY_TOTAL)))
        else $error("last_key beyond scanned keys");

    // A stalled result beat holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_pressed)
            && $stable(result_held) && $stable(result_last_key))
        else $error("stalled result changed");

    // Threshold writes are never refused.
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("threshold write refused");

endmodule

bind keypad_press_hold_detector kphd_checker #(
    .ROW_COUNT    (ROW_COUNT),
    .COLUMN_COUNT (COLUMN_COUNT)
) u_kphd_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .frame_ready     (frame.ready),
    .cfg_valid       (cfg.valid),
    .cfg_ready       (cfg.ready),
    .result_valid    (result.valid),
    .result_ready    (result.ready),
    .result_pressed  (result.pressed),
    .result_held     (result.held),
    .result_last_key (result.last_key)
);
